// ===== hw/rtl/clipped_rle_sprite_blitter_top_macros.svh =====
// assertion macros used by the rtl top
`ifndef CLIPPED_RLE_SPRITE_BLITTER_TOP_MACROS_SVH
`define CLIPPED_RLE_SPRITE_BLITTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition implies consequence in the same cycle
`define CRSB_ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// condition implies consequence in the next cycle
`define CRSB_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define CRSB_ASSERT_SAME(label, clk, rst, cond, cons)
`define CRSB_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// ===== hw/rtl/crsb_pkg.sv =====
package crsb_pkg;

  localparam int MAX_DIM_DEF = 1024;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_FIRST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LAST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAINT_COLOR  = 3'd6;

  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_SOLID  = 2'd1;
  localparam logic [1:0] MODE_FILLED = 2'd2;

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_PIX  = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_SPAN  = 1'b1;

  typedef struct packed {
    logic [9:0] sprite_width;
    logic [9:0] clip_left;
    logic [9:0] clip_right;
    logic [9:0] row_first;
    logic [9:0] row_last;
    logic [1:0] draw_mode;
    logic [7:0] paint_color;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [9:0] row;
    logic [9:0] column;
    logic [7:0] length;
    logic [7:0] value;
  } wr_t;

endpackage

// ===== hw/rtl/clipped_rle_sprite_blitter_top.sv =====
// channel  | direction | handshake                  | payload
// code     | in        | code_valid / code_ready    | code_byte
// write    | out       | write_valid / write_ready  | write_kind, pixel_row, pixel_column,
//          |           |                            | span_length, pixel_value
// cfg      | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// one code byte per cycle while writes are not stalled; a byte is held in the input
// register, and its write, if any, is loaded into the output register when its decode step moves
// the decode step moves only when the output register is empty or being drained
// a stalled write holds a full input register, and code_ready is low meanwhile
// rst clears the decode state and loads the register reset values

`include "clipped_rle_sprite_blitter_top_macros.svh"

module clipped_rle_sprite_blitter_top
  import crsb_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  code_valid,
  output logic                  code_ready,
  input  logic [7:0]            code_byte,
  output logic                  write_valid,
  input  logic                  write_ready,
  output logic                  write_kind,
  output logic [9:0]            pixel_row,
  output logic [9:0]            pixel_column,
  output logic [7:0]            span_length,
  output logic [7:0]            pixel_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       hold;
  logic [7:0] hold_byte;
  logic       advance;
  logic       emit;
  wr_t        wr;
  wr_t        out_wr;

  assign cfg_ready  = 1'b1;
  assign advance    = hold && (!write_valid || write_ready);
  assign code_ready = !hold || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sprite_width <= 10'd1;
      cfg.clip_left    <= 10'd0;
      cfg.clip_right   <= 10'd1023;
      cfg.row_first    <= 10'd0;
      cfg.row_last     <= 10'd1023;
      cfg.draw_mode    <= MODE_COPY;
      cfg.paint_color  <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPRITE_WIDTH: cfg.sprite_width <= cfg_data;
        REG_CLIP_LEFT:    cfg.clip_left    <= cfg_data;
        REG_CLIP_RIGHT:   cfg.clip_right   <= cfg_data;
        REG_ROW_FIRST:    cfg.row_first    <= cfg_data;
        REG_ROW_LAST:     cfg.row_last     <= cfg_data;
        REG_DRAW_MODE:    cfg.draw_mode    <= cfg_data[1:0];
        REG_PAINT_COLOR:  cfg.paint_color  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (code_ready) begin
      hold <= code_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (code_valid && code_ready) begin
      hold_byte <= code_byte;
    end
  end

  crsb_decoder #(
    .MAX_DIM(MAX_DIM)
  ) u_decoder (
    .clk (clk),
    .rst (rst),
    .step(advance),
    .code(hold_byte),
    .cfg (cfg),
    .emit(emit),
    .wr  (wr)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      write_valid <= 1'b0;
    end else if (!write_valid || write_ready) begin
      write_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_wr <= wr;
    end
  end

  assign write_kind   = out_wr.kind;
  assign pixel_row    = out_wr.row;
  assign pixel_column = out_wr.column;
  assign span_length  = out_wr.length;
  assign pixel_value  = out_wr.value;

  `CRSB_ASSERT_SAME(a_stall_blocks_input, clk, rst, hold && write_valid && !write_ready, !code_ready)
  `CRSB_ASSERT_SAME(a_pixel_len_one, clk, rst, write_valid && (write_kind == KIND_PIXEL), span_length == 8'd1)
  `CRSB_ASSERT_SAME(a_span_color, clk, rst, write_valid && (write_kind == KIND_SPAN), pixel_value == cfg.paint_color)
  `CRSB_ASSERT_NEXT(a_step_loads_out, clk, rst, advance && emit, write_valid)

endmodule

// ===== hw/rtl/crsb_decoder.sv =====
module crsb_decoder
  import crsb_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] code,
  input  cfg_t       cfg,
  output logic       emit,
  output wr_t        wr
);

  localparam int ROW_W = $clog2(MAX_DIM);
  localparam int CMP_W = (ROW_W > 10) ? ROW_W : 10;
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_DIM - 1);

  logic [1:0]       phase;
  logic [1:0]       phase_next;
  logic [9:0]       column;
  logic [9:0]       column_next;
  logic [7:0]       run_left;
  logic [7:0]       run_left_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;

  logic [CMP_W-1:0] row_ext;
  logic             row_vis;
  logic             in_width;
  logic [9:0]       col_inc;
  logic [7:0]       run_dec;
  logic [10:0]      sum;
  logic [9:0]       stop;
  logic [9:0]       lo;
  logic [9:0]       hi;
  logic [9:0]       span;
  logic [ROW_W-1:0] row_wrap;

  assign row_ext  = CMP_W'(row);
  assign row_vis  = (row_ext >= CMP_W'(cfg.row_first)) && (row_ext <= CMP_W'(cfg.row_last));
  assign in_width = column < cfg.sprite_width;
  assign col_inc  = in_width ? column + 10'd1 : column;
  assign run_dec  = run_left - 8'd1;
  assign sum      = {1'b0, column} + {3'b000, code};
  assign stop     = (sum > {1'b0, cfg.sprite_width}) ? cfg.sprite_width : sum[9:0];
  assign lo       = (column > cfg.clip_left) ? column : cfg.clip_left;
  assign hi       = ((stop - 10'd1) > cfg.clip_right) ? cfg.clip_right : stop - 10'd1;
  assign span     = hi - lo + 10'd1;
  assign row_wrap = (row == ROW_MAX) ? '0 : row + ROW_W'(1);

  always_comb begin
    phase_next    = phase;
    column_next   = column;
    run_left_next = run_left;
    row_next      = row;
    emit          = 1'b0;
    wr.kind       = KIND_PIXEL;
    wr.row        = row_ext[9:0];
    wr.column     = column;
    wr.length     = 8'd1;
    wr.value      = (cfg.draw_mode == MODE_SOLID) ? cfg.paint_color : code;
    unique case (phase)
      PH_RUN: begin
        if (code == 8'd0) begin
          phase_next = PH_SKIP;
        end else begin
          run_left_next = code;
          phase_next    = PH_PIX;
        end
      end
      PH_PIX: begin
        emit = in_width && row_vis && (column >= cfg.clip_left) &&
               (column <= cfg.clip_right);
        column_next   = col_inc;
        run_left_next = run_dec;
        if (run_dec == 8'd0) begin
          if (col_inc >= cfg.sprite_width) begin
            column_next = '0;
            row_next    = row_wrap;
            phase_next  = PH_SKIP;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      default: begin
        // skip byte, with an optional clipped fill span
        wr.kind   = KIND_SPAN;
        wr.column = lo;
        wr.length = span[7:0];
        wr.value  = cfg.paint_color;
        emit = (cfg.draw_mode == MODE_FILLED) && (code != 8'd0) && row_vis &&
               (stop > column) && (lo <= hi);
        if (stop >= cfg.sprite_width) begin
          column_next = '0;
          row_next    = row_wrap;
          phase_next  = PH_SKIP;
        end else begin
          column_next = stop;
          phase_next  = PH_RUN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SKIP;
      column   <= '0;
      run_left <= '0;
      row      <= '0;
    end else if (step) begin
      phase    <= phase_next;
      column   <= column_next;
      run_left <= run_left_next;
      row      <= row_next;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import crsb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic code_valid = 1'b0;
  logic code_ready;
  logic [7:0] code_byte = '0;
  logic write_valid;
  logic write_ready = 1'b0;
  logic write_kind;
  logic [9:0] pixel_row;
  logic [9:0] pixel_column;
  logic [7:0] span_length;
  logic [7:0] pixel_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  clipped_rle_sprite_blitter_top uut (
    .clk(clk),
    .rst(rst),
    .code_valid(code_valid),
    .code_ready(code_ready),
    .code_byte(code_byte),
    .write_valid(write_valid),
    .write_ready(write_ready),
    .write_kind(write_kind),
    .pixel_row(pixel_row),
    .pixel_column(pixel_column),
    .span_length(span_length),
    .pixel_value(pixel_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [7:0] stream_q[$];
  wr_t pending_writes[$];
  int bytes_queued = 0;
  int mismatches = 0;

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_trigger = 0;
  int hold_seen = 0;

  // decoder shadow state
  logic [1:0] dec_phase;
  int col_pos;
  logic [7:0] run_left;
  logic [9:0] row_pos;
  cfg_t sprite_cfg;

  function automatic void next_row();
    col_pos = 0;
    row_pos = row_pos + 10'd1;
    dec_phase = PH_SKIP;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output wr_t w);
    int sw, cl, cr, lo, hi, stop;
    bit vis, hit;
    logic [7:0] len8, pix;
    sw = int'(sprite_cfg.sprite_width);
    cl = int'(sprite_cfg.clip_left);
    cr = int'(sprite_cfg.clip_right);
    vis = row_pos >= sprite_cfg.row_first && row_pos <= sprite_cfg.row_last;
    hit = 1'b0;
    w = '0;
    if (dec_phase == PH_RUN) begin
      if (b == 8'd0) begin
        dec_phase = PH_SKIP;
      end else begin
        run_left = b;
        dec_phase = PH_PIX;
      end
    end else if (dec_phase == PH_PIX) begin
      if (col_pos < sw && vis && col_pos >= cl && col_pos <= cr) begin
        pix = (sprite_cfg.draw_mode == MODE_SOLID) ? sprite_cfg.paint_color : b;
        w = {KIND_PIXEL, row_pos, col_pos[9:0], 8'd1, pix};
        hit = 1'b1;
      end
      if (col_pos < sw) col_pos = col_pos + 1;
      run_left = run_left - 8'd1;
      if (run_left == 8'd0) begin
        if (col_pos >= sw) next_row();
        else dec_phase = PH_SKIP;
      end
    end else begin
      stop = col_pos + int'(b);
      if (stop > sw) stop = sw;
      if (sprite_cfg.draw_mode == MODE_FILLED && b != 8'd0 && vis && stop > col_pos) begin
        lo = (col_pos > cl) ? col_pos : cl;
        hi = (stop - 1 > cr) ? cr : stop - 1;
        if (lo <= hi) begin
          len8 = 8'(hi - lo + 1);
          w = {KIND_SPAN, row_pos, lo[9:0], len8, sprite_cfg.paint_color};
          hit = 1'b1;
        end
      end
      col_pos = stop;
      if (col_pos >= sw) next_row();
      else dec_phase = PH_RUN;
    end
    return hit;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    wr_t got, want, nxt;
    if (rst) begin
      dec_phase = PH_SKIP;
      col_pos = 0;
      run_left = '0;
      row_pos = '0;
      sprite_cfg = '{10'd1, 10'd0, 10'd1023, 10'd0, 10'd1023, MODE_COPY, 8'd0};
      pending_writes.delete();
    end else begin
      if (write_valid && write_ready) begin
        got = {write_kind, pixel_row, pixel_column, span_length, pixel_value};
        if (pending_writes.size() == 0) begin
          mismatches++;
          $display("%0t: write expected none actual %h", $time, got);
        end else begin
          want = pending_writes.pop_front();
          check_field("write_kind", int'(want.kind), int'(got.kind));
          check_field("pixel_row", int'(want.row), int'(got.row));
          check_field("pixel_column", int'(want.column), int'(got.column));
          check_field("span_length", int'(want.length), int'(got.length));
          check_field("pixel_value", int'(want.value), int'(got.value));
        end
      end
      if (code_valid && code_ready) begin
        if (decode_byte(code_byte, nxt)) pending_writes.push_back(nxt);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPRITE_WIDTH: sprite_cfg.sprite_width = cfg_data;
          REG_CLIP_LEFT:    sprite_cfg.clip_left = cfg_data;
          REG_CLIP_RIGHT:   sprite_cfg.clip_right = cfg_data;
          REG_ROW_FIRST:    sprite_cfg.row_first = cfg_data;
          REG_ROW_LAST:     sprite_cfg.row_last = cfg_data;
          REG_DRAW_MODE:    sprite_cfg.draw_mode = cfg_data[1:0];
          REG_PAINT_COLOR:  sprite_cfg.paint_color = cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // code byte driver
  always @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      send_gap <= 0;
    end else if (!code_valid || code_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        code_valid <= 1'b0;
      end else if (stream_q.size() != 0 && send_idle && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 13);
        code_valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        code_valid <= 1'b1;
        code_byte <= stream_q.pop_front();
      end else begin
        code_valid <= 1'b0;
      end
    end
  end

  // write receiver
  always @(posedge clk) begin
    if (rst) begin
      write_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      write_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      write_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      write_ready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      write_ready <= 1'b0;
    end else begin
      write_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (code_valid && code_ready) || (write_valid && write_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  task automatic queue_byte(input logic [7:0] b);
    stream_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (stream_q.size() != 0 || code_valid || pending_writes.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  // bring the decoder back to the start of a row
  task automatic realign();
    while (dec_phase != PH_SKIP || col_pos != 0) begin
      if (dec_phase == PH_RUN) queue_byte(8'd0);
      else if (dec_phase == PH_PIX) repeat (run_left) queue_byte(8'($urandom));
      else queue_byte(8'd255);
      drain();
    end
  endtask

  task automatic program_sprite(input logic [9:0] w, cl, cr, rf, rl, md, color);
    drain();
    write_reg(REG_SPRITE_WIDTH, w);
    write_reg(REG_CLIP_LEFT, cl);
    write_reg(REG_CLIP_RIGHT, cr);
    write_reg(REG_ROW_FIRST, rf);
    write_reg(REG_ROW_LAST, rl);
    write_reg(REG_DRAW_MODE, md);
    write_reg(REG_PAINT_COLOR, color);
    cfg_valid <= 1'b0;
    realign();
  endtask

  task automatic queue_row(input int w);
    int c, rem, lim, s, r;
    c = 0;
    forever begin
      rem = w - c;
      lim = (rem > 255) ? 255 : rem;
      case ($urandom_range(0, 9))
        0, 1: s = 0;
        8: s = lim;
        9: begin
          s = rem + $urandom_range(1, 20);
          if (s > 255) s = 255;
        end
        default: s = $urandom_range(0, lim);
      endcase
      queue_byte(s[7:0]);
      c = c + s;
      if (c >= w) break;
      rem = w - c;
      lim = (rem > 255) ? 255 : rem;
      case ($urandom_range(0, 9))
        0: r = 0;
        8: r = lim;
        9: begin
          r = rem + $urandom_range(1, 6);
          if (r > 255) r = 255;
        end
        default: r = $urandom_range(1, lim);
      endcase
      queue_byte(r[7:0]);
      repeat (r) queue_byte(8'($urandom));
      if (r != 0) begin
        c = c + r;
        if (c >= w) break;
      end
    end
  endtask

  task automatic run_rows(input int w, input int n);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < n) queue_row(w);
    // stray bytes that break the row structure
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
  endtask

  task automatic random_phase(input int n, input bit pause_mid);
    logic [9:0] w, cl, cr, rf, rl;
    case ($urandom_range(0, 9))
      0: w = 10'd0;
      1: w = 10'd1;
      2: w = 10'($urandom_range(25, 160));
      default: w = 10'($urandom_range(2, 24));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      cl = 10'd0;
      cr = 10'd1023;
    end else begin
      cl = 10'($urandom_range(0, w + 2));
      cr = 10'($urandom_range(0, w + 2));
    end
    if ($urandom_range(0, 1)) begin
      rf = 10'd0;
      rl = 10'd1023;
    end else begin
      rf = row_pos + 10'($urandom_range(0, 3));
      rl = rf + 10'($urandom_range(0, 40));
    end
    send_idle <= ($urandom_range(0, 3) != 0);
    recv_idle <= ($urandom_range(0, 3) != 0);
    program_sprite(w, cl, cr, rf, rl, {8'($urandom), 2'($urandom_range(0, 3))},
                   10'($urandom));
    if (pause_mid) begin
      run_rows(int'(w), n / 2);
      drain();
      run_rows(int'(w), n / 2);
    end else begin
      run_rows(int'(w), n);
    end
  endtask

  initial begin : stimulus
    logic [7:0] seq_filled [20] = '{8'd3, 8'd3, 8'h00, 8'hFF, 8'h80, 8'd0, 8'd0, 8'd255,
                                    8'd0, 8'd10, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                    8'h20, 8'h40, 8'h80, 8'h7F, 8'hFE};
    logic [7:0] seq_solid [5] = '{8'd1, 8'd2, 8'h55, 8'hAA, 8'd1};
    int rows_left;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: filled mode with clipping, zero runs, overlong skip and run; solid mode; zero width
    write_reg(REG_UNUSED, 10'h3FF);
    cfg_valid <= 1'b0;
    program_sprite(10'd8, 10'd2, 10'd5, 10'd0, 10'd1023, {8'd0, MODE_FILLED}, 10'h0A5);
    foreach (seq_filled[i]) queue_byte(seq_filled[i]);
    program_sprite(10'd4, 10'd0, 10'd3, 10'd0, 10'd1023, {8'd0, MODE_SOLID}, 10'h03C);
    foreach (seq_solid[i]) queue_byte(seq_solid[i]);
    program_sprite(10'd0, 10'd0, 10'd1023, 10'd0, 10'd1023, {8'd0, MODE_FILLED}, 10'h3FF);
    queue_byte(8'd0);
    queue_byte(8'd255);

    // register extremes
    program_sprite(10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, {8'hFF, MODE_FILLED},
                   10'h0FF);
    run_rows(1023, 1);
    program_sprite(10'd12, 10'd9, 10'd3, 10'd0, 10'd1023, {8'd0, MODE_FILLED}, 10'h011);
    run_rows(12, 40);
    program_sprite(10'd12, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'h003, 10'h022);
    run_rows(12, 40);
    program_sprite(10'd20, 10'd1023, 10'd1023, 10'd0, 10'd1023, {8'd0, MODE_COPY}, 10'h000);
    run_rows(20, 40);

    // receiver backs off while bytes keep coming
    program_sprite(10'd16, 10'd0, 10'd1023, 10'd0, 10'd1023, {8'd0, MODE_COPY}, 10'h000);
    hold_trigger <= hold_trigger + 1;
    run_rows(16, 40);
    random_phase(70, 1'b0);
    random_phase(70, 1'b1);
    repeat (2) random_phase(50, 1'b0);

    // final stretch, no idling: many short rows so the row counter wraps
    send_idle <= 1'b0;
    recv_idle <= 1'b0;
    program_sprite(10'd1, 10'd0, 10'd0, 10'd0, 10'd1023, {8'($urandom), MODE_FILLED},
                   10'($urandom));
    rows_left = 1024 - int'(row_pos) + 40;
    repeat (rows_left) begin
      if ($urandom_range(0, 19) != 0) begin
        queue_byte(8'($urandom_range(1, 255)));
      end else begin
        queue_byte(8'd0);
        queue_byte(8'd1);
        queue_byte(8'($urandom));
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/crsb_pkg.sv
hw/rtl/crsb_decoder.sv
hw/rtl/clipped_rle_sprite_blitter_top.sv
sim/tb_top.sv
